>>> hw/rtl/sfr_pkg.sv
`default_nettype none
package sfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int REP_MAX = 16;                      // bytes in pattern and replacement regs
  localparam int CNT_W   = $clog2(REP_MAX + 1);     // holds 0..REP_MAX
  localparam int Q_DEPTH = 2;                       // command queue entries

  typedef logic [REP_MAX-1:0][BYTE_W-1:0] byte_vec_t;

  typedef enum logic [2:0] {
    CFG_PAT_LO  = 3'd0,
    CFG_PAT_HI  = 3'd1,
    CFG_PAT_LEN = 3'd2,
    CFG_REP_LO  = 3'd3,
    CFG_REP_HI  = 3'd4,
    CFG_REP_LEN = 3'd5
  } cfg_idx_t;

  // One command from the classifier to the emitter: a run of bytes to send.
  // A zero count with last set means a bare end marker.
  typedef struct packed {
    byte_vec_t        data;
    logic [CNT_W-1:0] count;
    logic             last;
  } sfr_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/sfr_front.sv
`default_nettype none
module sfr_front
  import sfr_pkg::*;
#(
  parameter int MAX_LEN = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  input  wire logic             win_clear,
  input  wire byte_vec_t        pattern,
  input  wire logic [CNT_W-1:0] plen,
  input  wire byte_vec_t        replace,
  input  wire logic [CNT_W-1:0] rlen,
  input  wire logic             q_ready,
  output logic                  q_push,
  output sfr_cmd_t              q_cmd
);

  localparam int WIN    = (MAX_LEN < REP_MAX) ? MAX_LEN : REP_MAX;
  localparam int FILL_W = $clog2(WIN + 1);

  logic [BYTE_W-1:0] win_r   [WIN];
  logic [BYTE_W-1:0] win_nxt [WIN];
  logic [BYTE_W-1:0] w_new   [WIN];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  fill_c;
  logic              accept, full, match, hit;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  always_comb begin
    fill_c = (CNT_W'(fill_r) >= plen) ? '0 : CNT_W'(fill_r);
    match  = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      w_new[i] = (CNT_W'(i) == fill_c) ? in_byte : win_r[i];
      if ((CNT_W'(i) < plen) && (w_new[i] != pattern[i])) begin
        match = 1'b0;
      end
    end
    full = ((fill_c + CNT_W'(1)) == plen);
    hit  = full && match;

    q_cmd.last = in_last;
    if (hit) begin
      q_cmd.data  = replace;
      q_cmd.count = rlen;
    end else begin
      q_cmd.data = '0;
      for (int i = 0; i < WIN; i++) begin
        q_cmd.data[i] = w_new[i];
      end
      if (in_last) begin
        q_cmd.count = fill_c + CNT_W'(1);
      end else if (full) begin
        q_cmd.count = CNT_W'(1);
      end else begin
        q_cmd.count = '0;
      end
    end
    q_push = accept && ((q_cmd.count != '0) || in_last);

    // advance the window: clear on a hit or a string end, drop the oldest byte when full
    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (accept) begin
      if (hit) begin
        fill_nxt = '0;
      end else if (full) begin
        for (int i = 0; i < WIN - 1; i++) begin
          win_nxt[i] = w_new[i + 1];
        end
        win_nxt[WIN-1] = w_new[WIN-1];
        fill_nxt = FILL_W'(plen - CNT_W'(1));
      end else begin
        win_nxt  = w_new;
        fill_nxt = FILL_W'(fill_c + CNT_W'(1));
      end
      if (in_last) begin
        fill_nxt = '0;
      end
    end
    if (win_clear) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  a_fill_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(fill_r) < plen)
    else $error("window fill reached pattern length");

endmodule
`default_nettype wire

>>> hw/rtl/sfr_queue.sv
`default_nettype none
module sfr_queue
  import sfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire sfr_cmd_t push_cmd,
  output logic          ready,
  input  wire logic     pop,
  output logic          head_valid,
  output sfr_cmd_t      head_cmd
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_QW = $clog2(Q_DEPTH + 1);

  sfr_cmd_t          mem_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] cnt_r, cnt_nxt;

  assign ready      = (cnt_r != CNT_QW'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_QW'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_QW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ready)
    else $error("push into full command queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty command queue");

endmodule
`default_nettype wire

>>> hw/rtl/sfr_back.sv
`default_nettype none
module sfr_back
  import sfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     head_valid,
  input  wire sfr_cmd_t head_cmd,
  output logic          pop,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tuser,
  output logic          out_tlast
);

  localparam int IDX_W = $clog2(REP_MAX);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             user_r, user_nxt, last_r, last_nxt;
  logic             fire, final_byte, bare;

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

  always_comb begin
    fire       = head_valid && (!valid_r || out_tready);
    bare       = (head_cmd.count == '0);
    final_byte = bare || (CNT_W'(idx_r) == (head_cmd.count - CNT_W'(1)));
    pop        = fire && final_byte;

    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    user_nxt  = user_r;
    last_nxt  = last_r;
    if (fire) begin
      valid_nxt = 1'b1;
      data_nxt  = bare ? '0 : head_cmd.data[idx_r];
      user_nxt  = !bare;
      last_nxt  = head_cmd.last && final_byte;
      idx_nxt   = final_byte ? '0 : idx_r + IDX_W'(1);
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("bare end marker without last");

endmodule
`default_nettype wire

>>> hw/rtl/stream_find_replace.sv
// Streaming find-and-replace of a fixed byte pattern.
// Input stream: one character per item on in_tdata, in_tlast on the final
// character of a string. Output stream: one character per item on
// out_tdata, out_tuser high when the item carries a character, low for a
// bare end marker (sent when a string ends with nothing left to emit), and
// out_tlast on the final item of the rewritten string.
// Pattern, its length, replacement and its length are written on the cfg
// port while the stream is idle; writing the pattern length empties the
// match window.
// From an accepted item, the first result is registered in the command queue
// and then in the output register. Throughput: one item per cycle while each
// item yields at most one result and the receiver is ready. A matched pattern
// yields the replacement bytes and a string end flushes the window, one result
// per cycle out of the emitter, so an item yielding more than one result keeps
// the emitter busy; the two-entry command queue then fills and in_tready drops.
// Reset clears the window and loads pattern length 1, replacement length 0
// and zero bytes. A stalled receiver holds the output register; the queue
// absorbs up to two commands before input stalls.
`default_nettype none
module stream_find_replace
  import sfr_pkg::*;
#(
  parameter int MAX_LEN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tuser,  // [0] out_valid
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [63:0] cfg_wdata
);

  localparam int WIN = (MAX_LEN < REP_MAX) ? MAX_LEN : REP_MAX;

  logic [63:0]      pat_lo_r, pat_hi_r, rep_lo_r, rep_hi_r;
  logic [CNT_W-1:0] plen_r, rlen_r, plen_eff, rlen_eff;
  logic             win_clear, q_ready, q_push, q_pop, head_valid;
  sfr_cmd_t         q_cmd, head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      plen_r   <= CNT_W'(1);
      rep_lo_r <= '0;
      rep_hi_r <= '0;
      rlen_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_PAT_LO:  pat_lo_r <= cfg_wdata;
        CFG_PAT_HI:  pat_hi_r <= cfg_wdata;
        CFG_PAT_LEN: plen_r   <= cfg_wdata[CNT_W-1:0];
        CFG_REP_LO:  rep_lo_r <= cfg_wdata;
        CFG_REP_HI:  rep_hi_r <= cfg_wdata;
        CFG_REP_LEN: rlen_r   <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign win_clear = cfg_we && (cfg_idx_t'(cfg_addr) == CFG_PAT_LEN);

  // saturate lengths: zero pattern means one byte, cap at register and window size
  always_comb begin
    plen_eff = plen_r;
    if (plen_eff == '0) begin
      plen_eff = CNT_W'(1);
    end
    if (plen_eff > CNT_W'(REP_MAX)) begin
      plen_eff = CNT_W'(REP_MAX);
    end
    if (plen_eff > CNT_W'(WIN)) begin
      plen_eff = CNT_W'(WIN);
    end
    rlen_eff = (rlen_r > CNT_W'(REP_MAX)) ? CNT_W'(REP_MAX) : rlen_r;
  end

  sfr_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .win_clear (win_clear),
    .pattern   (byte_vec_t'({pat_hi_r, pat_lo_r})),
    .plen      (plen_eff),
    .replace   (byte_vec_t'({rep_hi_r, rep_lo_r})),
    .rlen      (rlen_eff),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  sfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

>>> bench/stream_find_replace_tb.sv
`default_nettype none
module stream_find_replace_tb;
  import sfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAND_ITEMS = 240;
  localparam int unsigned SETTLE     = 6;     // covers the command queue and output register
  localparam int unsigned LIMIT      = 2000;

  // One character of the rewritten string as the block should send it.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } char_t;

  typedef enum logic [1:0] {ROW_SET, ROW_CHAR, ROW_CHAR_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_idx_t    idx;
    logic [63:0] value;
    logic [7:0]  b;
    logic        l;
    char_t       want;
  } row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] in_byte
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_addr   = 3'd0;
  logic [63:0] cfg_wdata  = 64'd0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;            // [7:0] out_byte
  logic        out_tuser;            // [0] out_valid
  logic        out_tlast;

  stream_find_replace dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial forever #6 clk = ~clk;

  // Mirror of the configuration and the match window.
  logic [63:0] pat_lo = '0, pat_hi = '0, rep_lo = '0, rep_hi = '0;
  logic [4:0]  pat_len_reg = 5'd1, rep_len_reg = 5'd0;
  logic [7:0]  win [16];
  int unsigned win_fill = 0;

  char_t       want_q[$];
  int unsigned errors = 0;
  bit          steady = 1'b0;

  function automatic logic [7:0] byte_at(logic [63:0] lo, logic [63:0] hi, int unsigned i);
    logic [63:0] w;
    w = (i < 8) ? lo : hi;
    return w[(i % 8) * 8 +: 8];
  endfunction

  function automatic int unsigned pat_len_eff();
    int unsigned p;
    p = pat_len_reg;
    if (p < 1) p = 1;
    if (p > 16) p = 16;
    return p;
  endfunction

  // Run one character through the window; queue what it yields when keep is set.
  function automatic void rewrite_byte(logic [7:0] b, logic last, bit keep);
    char_t       res[$];
    int unsigned plen, rlen;
    bit          hit;
    plen = pat_len_eff();
    rlen = (rep_len_reg > 16) ? 16 : rep_len_reg;
    if (win_fill >= plen) win_fill = 0;
    win[win_fill] = b;
    win_fill++;
    if (win_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (win[i] != byte_at(pat_lo, pat_hi, i)) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < rlen; i++) res.push_back({byte_at(rep_lo, rep_hi, i), 1'b1, 1'b0});
        win_fill = 0;
      end else begin
        res.push_back({win[0], 1'b1, 1'b0});
        for (int i = 0; i + 1 < plen; i++) win[i] = win[i + 1];
        win_fill--;
      end
    end
    if (last) begin
      for (int i = 0; i < win_fill; i++) res.push_back({win[i], 1'b1, 1'b0});
      win_fill = 0;
      // string end with nothing to send: bare end marker
      if (res.size() == 0) res.push_back({8'h00, 1'b0, 1'b0});
      res[res.size() - 1].last = 1'b1;
    end
    if (keep) foreach (res[k]) want_q.push_back(res[k]);
  endfunction

  // Mostly no pause, some short ones, a few long.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [63:0] reg_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Write one register once the block has gone quiet.
  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PAT_LO:  pat_lo = val;
      CFG_PAT_HI:  pat_hi = val;
      CFG_PAT_LEN: begin
        pat_len_reg = val[4:0];
        win_fill = 0;
      end
      CFG_REP_LO:  rep_lo = val;
      CFG_REP_HI:  rep_hi = val;
      CFG_REP_LEN: rep_len_reg = val[4:0];
      default: ;
    endcase
  endtask

  task automatic send_char(logic [7:0] b, logic l, bit keep);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rewrite_byte(b, l, keep);
    gap = pause_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: check, then pick the next ready level.
  int unsigned sink_wait = 0;
  char_t       got_want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (want_q.size() == 0) begin
        $display("%0t: unexpected item data=%02h user=%b last=%b",
                 $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        got_want = want_q.pop_front();
        if (out_tdata !== got_want.data || out_tuser !== got_want.valid ||
            out_tlast !== got_want.last) begin
          $display("%0t: mismatch want data=%02h user=%b last=%b got data=%02h user=%b last=%b",
                   $time, got_want.data, got_want.valid, got_want.last,
                   out_tdata, out_tuser, out_tlast);
          errors++;
        end
      end
    end
    if (sink_wait > 0) begin
      out_tready <= 1'b0;
      sink_wait--;
    end else begin
      out_tready <= 1'b1;
      sink_wait = pause_len();
    end
  end

  int unsigned quiet = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d items still due",
                 $time, LIMIT, want_q.size());
        $display("stream_find_replace_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    row_t        plan[$];
    logic [7:0]  word[$];
    int unsigned plen, phase_n, phase_sent, total, nstr, pick, cnt;
    bit          cut;

    // after reset: pattern is one zero byte, replacement is empty
    plan.push_back('{ROW_CHAR_KNOWN, CFG_PAT_LO, 64'd0, 8'h41, 1'b1, {8'h41, 1'b1, 1'b1}});
    plan.push_back('{ROW_CHAR_KNOWN, CFG_PAT_LO, 64'd0, 8'h00, 1'b1, {8'h00, 1'b0, 1'b1}});
    plan.push_back('{ROW_CHAR_KNOWN, CFG_PAT_LO, 64'd0, 8'hFF, 1'b1, {8'hFF, 1'b1, 1'b1}});
    // "ab" -> "XYZ", back-to-back matches
    plan.push_back('{ROW_SET, CFG_PAT_LO, 64'h6261, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_SET, CFG_PAT_LEN, 64'd2, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_SET, CFG_REP_LO, 64'h5A5958, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_SET, CFG_REP_LEN, 64'd3, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h78, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h61, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h62, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h61, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h62, 1'b1, 10'h0});
    // zero pattern length acts as one, oversized replacement length saturates
    plan.push_back('{ROW_SET, CFG_REP_LO, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_SET, CFG_REP_HI, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_SET, CFG_REP_LEN, 64'd31, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_SET, CFG_PAT_LEN, 64'd0, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h61, 1'b1, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h62, 1'b0, 10'h0});
    // oversized pattern length saturates, short string flushes
    plan.push_back('{ROW_SET, CFG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_SET, CFG_PAT_LEN, 64'd31, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h61, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h62, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h63, 1'b1, 10'h0});
    // pattern length rewritten mid-string drops the held bytes
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h71, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h72, 1'b0, 10'h0});
    plan.push_back('{ROW_SET, CFG_PAT_LEN, 64'd2, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h73, 1'b1, 10'h0});
    // empty replacement deletes the match, leaving a bare end marker
    plan.push_back('{ROW_SET, CFG_PAT_HI, 64'd0, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_SET, CFG_REP_LEN, 64'd0, 8'h00, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR, CFG_PAT_LO, 64'd0, 8'h61, 1'b0, 10'h0});
    plan.push_back('{ROW_CHAR_KNOWN, CFG_PAT_LO, 64'd0, 8'h62, 1'b1, {8'h00, 1'b0, 1'b1}});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_SET:  write_reg(plan[i].idx, plan[i].value);
        ROW_CHAR: send_char(plan[i].b, plan[i].l, 1'b1);
        default: begin
          want_q.push_back(plan[i].want);
          send_char(plan[i].b, plan[i].l, 1'b0);
        end
      endcase
    end

    total = 0;
    nstr  = 0;
    while (total < RAND_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      write_reg(CFG_PAT_LO, reg_value());
      write_reg(CFG_PAT_HI, reg_value());
      write_reg(CFG_REP_LO, reg_value());
      write_reg(CFG_REP_HI, reg_value());
      case ($urandom_range(0, 9))
        0: write_reg(CFG_PAT_LEN, 64'd0);
        1: write_reg(CFG_PAT_LEN, 64'($urandom_range(17, 31)));
        2: write_reg(CFG_PAT_LEN, 64'd16);
        3: write_reg(CFG_PAT_LEN, 64'($urandom_range(5, 15)));
        default: write_reg(CFG_PAT_LEN, 64'($urandom_range(1, 4)));
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(CFG_REP_LEN, 64'd0);
        1: write_reg(CFG_REP_LEN, 64'($urandom_range(17, 31)));
        2: write_reg(CFG_REP_LEN, 64'd16);
        default: write_reg(CFG_REP_LEN, 64'($urandom_range(0, 5)));
      endcase
      plen       = pat_len_eff();
      phase_n    = $urandom_range(20, 60);
      phase_sent = 0;
      while (phase_sent < phase_n) begin
        // build a string mostly out of pattern copies, with prefixes and noise
        word.delete();
        repeat ($urandom_range(1, 4)) begin
          pick = $urandom_range(0, 19);
          if (pick < 12) begin
            for (int k = 0; k < plen; k++) word.push_back(byte_at(pat_lo, pat_hi, k));
          end else if (pick < 15) begin
            cnt = $urandom_range(1, plen);
            for (int k = 0; k < cnt; k++) word.push_back(byte_at(pat_lo, pat_hi, k));
          end else if (pick < 18) begin
            repeat ($urandom_range(1, 3)) word.push_back(8'($urandom_range(0, 255)));
          end else begin
            word.push_back(byte_at(pat_lo, pat_hi, $urandom_range(0, plen - 1)));
          end
        end
        cut = (phase_sent + word.size() >= phase_n) && ($urandom_range(0, 3) == 0);
        // hold the input until the block has drained
        if (nstr == 2 || $urandom_range(0, 9) == 0) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (want_q.size() != 0) @(posedge clk);
        end
        foreach (word[k]) send_char(word[k], (k == word.size() - 1) && !cut, 1'b1);
        phase_sent += word.size();
        total      += word.size();
        nstr++;
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (SETTLE + 4) @(posedge clk);
    if (errors == 0) begin
      $display("stream_find_replace_tb: PASS");
    end else begin
      $display("stream_find_replace_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
